@@ rtl/stm_pkg.sv @@
`timescale 1ns / 1ps

package stm_pkg;

  localparam int unsigned WD_DIV   = 128;
  localparam int unsigned WD_PRE_W = (WD_DIV > 1) ? $clog2(WD_DIV) : 1;
  localparam int unsigned RT_BITS  = 20;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned SPAN_W   = 17;

  localparam logic [SPAN_W-1:0] SPAN_MAX     = 17'h10000;
  localparam logic [17:0]       WD_MODE_RST  = 18'h20000;
  localparam logic [19:0]       RT_MODE_RST  = 20'h80000;

  localparam int unsigned FLAG_PIT = 0;
  localparam int unsigned FLAG_WDT = 1;
  localparam int unsigned FLAG_RTT = 2;
  localparam int unsigned FLAG_ALM = 3;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2
  } stm_action_e;

  typedef enum logic [3:0] {
    REG_CR   = 4'd0,
    REG_PIMR = 4'd1,
    REG_WDMR = 4'd2,
    REG_RTMR = 4'd3,
    REG_SR   = 4'd4,
    REG_IER  = 4'd5,
    REG_IDR  = 4'd6,
    REG_IMR  = 4'd7,
    REG_RTAR = 4'd8,
    REG_CRTR = 4'd9
  } stm_reg_e;

  typedef struct packed {
    stm_action_e       action;
    stm_reg_e          reg_index;
    logic [DATA_W-1:0] write_data;
  } stm_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq;
  } stm_rsp_t;

  // A zero interval stands for the full 16-bit span.
  function automatic logic [SPAN_W-1:0] span16(input logic [15:0] v);
    logic [SPAN_W-1:0] r;
    r = (v == 16'd0) ? SPAN_MAX : {1'b0, v};
    return r;
  endfunction

endpackage

@@ rtl/stm_core.sv @@
`timescale 1ns / 1ps

module stm_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  stm_pkg::stm_req_t req_i,
  output stm_pkg::stm_rsp_t rsp_o
);
  import stm_pkg::*;

  logic [15:0]         pit_value_q, pit_value_d;
  logic [SPAN_W-1:0]   pit_count_q, pit_count_d;
  logic [17:0]         wd_mode_q, wd_mode_d;
  logic [SPAN_W-1:0]   wd_count_q, wd_count_d;
  logic [WD_PRE_W-1:0] wd_pre_q, wd_pre_d;
  logic [19:0]         rt_mode_q, rt_mode_d;
  logic [SPAN_W-1:0]   rt_pre_q, rt_pre_d;
  logic [RT_BITS-1:0]  rt_count_q, rt_count_d;
  logic [RT_BITS-1:0]  alarm_q, alarm_d;
  logic [3:0]          status_q, status_d;
  logic [3:0]          mask_q, mask_d;

  logic [SPAN_W-1:0]   pit_dec;
  logic [SPAN_W-1:0]   wd_dec;
  logic [SPAN_W-1:0]   rt_pre_inc;
  logic [RT_BITS-1:0]  rt_inc;
  logic [DATA_W-1:0]   rd_data;

  assign pit_dec    = pit_count_q - SPAN_W'(1);
  assign wd_dec     = wd_count_q - SPAN_W'(1);
  assign rt_pre_inc = rt_pre_q + SPAN_W'(1);
  assign rt_inc     = rt_count_q + RT_BITS'(1);

  always_comb begin
    pit_value_d = pit_value_q;
    pit_count_d = pit_count_q;
    wd_mode_d   = wd_mode_q;
    wd_count_d  = wd_count_q;
    wd_pre_d    = wd_pre_q;
    rt_mode_d   = rt_mode_q;
    rt_pre_d    = rt_pre_q;
    rt_count_d  = rt_count_q;
    alarm_d     = alarm_q;
    status_d    = status_q;
    mask_d      = mask_q;
    rd_data     = '0;

    if (step_i) begin
      unique case (req_i.action)
        ACT_TICK: begin
          if (pit_dec == '0) begin
            status_d[FLAG_PIT] = 1'b1;
            pit_count_d        = span16(pit_value_q);
          end else begin
            pit_count_d = pit_dec;
          end

          if (wd_pre_q == WD_PRE_W'(WD_DIV - 1)) begin
            wd_pre_d = '0;
            if (wd_dec == '0) begin
              status_d[FLAG_WDT] = 1'b1;
              wd_count_d         = span16(wd_mode_q[15:0]);
            end else begin
              wd_count_d = wd_dec;
            end
          end else begin
            wd_pre_d = wd_pre_q + WD_PRE_W'(1);
          end

          if (rt_pre_inc >= span16(rt_mode_q[15:0])) begin
            rt_pre_d           = '0;
            rt_count_d         = rt_inc;
            status_d[FLAG_RTT] = 1'b1;
            if (rt_inc == alarm_q) begin
              status_d[FLAG_ALM] = 1'b1;
            end
          end else begin
            rt_pre_d = rt_pre_inc;
          end
        end

        ACT_READ: begin
          unique case (req_i.reg_index)
            REG_PIMR: rd_data = DATA_W'(pit_value_q);
            REG_WDMR: rd_data = DATA_W'(wd_mode_q);
            REG_RTMR: rd_data = DATA_W'(rt_mode_q);
            REG_SR: begin
              rd_data  = DATA_W'(status_q);
              status_d = '0;
            end
            REG_IMR:  rd_data = DATA_W'(mask_q);
            REG_RTAR: rd_data = DATA_W'(alarm_q);
            REG_CRTR: rd_data = DATA_W'(rt_count_q);
            default:  rd_data = '0;
          endcase
        end

        ACT_WRITE: begin
          unique case (req_i.reg_index)
            REG_CR: begin
              if (req_i.write_data[0]) begin
                wd_count_d = span16(wd_mode_q[15:0]);
                wd_pre_d   = '0;
              end
            end
            REG_PIMR: begin
              pit_value_d = req_i.write_data[15:0];
              pit_count_d = span16(req_i.write_data[15:0]);
            end
            REG_WDMR: wd_mode_d = req_i.write_data[17:0];
            REG_RTMR: begin
              rt_mode_d = req_i.write_data[19:0];
              rt_pre_d  = '0;
            end
            REG_IER:  mask_d = mask_q | req_i.write_data[3:0];
            REG_IDR:  mask_d = mask_q & ~req_i.write_data[3:0];
            REG_RTAR: alarm_d = req_i.write_data[RT_BITS-1:0];
            default: begin
            end
          endcase
        end

        default: begin
        end
      endcase
    end
  end

  assign rsp_o.read_data = rd_data;
  assign rsp_o.irq       = |(status_d & mask_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pit_value_q <= '0;
      pit_count_q <= SPAN_MAX;
      wd_mode_q   <= WD_MODE_RST;
      wd_count_q  <= SPAN_MAX;
      wd_pre_q    <= '0;
      rt_mode_q   <= RT_MODE_RST;
      rt_pre_q    <= '0;
      rt_count_q  <= '0;
      alarm_q     <= '0;
      status_q    <= '0;
      mask_q      <= '0;
    end else begin
      pit_value_q <= pit_value_d;
      pit_count_q <= pit_count_d;
      wd_mode_q   <= wd_mode_d;
      wd_count_q  <= wd_count_d;
      wd_pre_q    <= wd_pre_d;
      rt_mode_q   <= rt_mode_d;
      rt_pre_q    <= rt_pre_d;
      rt_count_q  <= rt_count_d;
      alarm_q     <= alarm_d;
      status_q    <= status_d;
      mask_q      <= mask_d;
    end
  end

`ifndef ASSERT_OFF
  a_pit_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pit_count_q != '0)
    else $error("period counter reached zero");

  a_wd_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wd_count_q != '0)
    else $error("watchdog counter reached zero");

  a_rt_pre_in_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rt_pre_q < span16(rt_mode_q[15:0]))
    else $error("real-time prescaler beyond its span");

  a_sr_read_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && req_i.action == ACT_READ && req_i.reg_index == REG_SR)
    |=> status_q == '0)
    else $error("status read did not clear the flags");
`endif

endmodule

@@ rtl/system_timer_pit_watchdog_rtc.sv @@
`timescale 1ns / 1ps

// System timer with a period interval timer, a watchdog and a real-time
// counter with an alarm, driven by words: a slow-clock tick, a register
// read or a register write. A word is taken into an input register, updates
// the timer state once the result register can take it and lands in that
// result register; one word is accepted every cycle as long as results are
// taken, and the result register is the only thing that can stall the input
// side.

module system_timer_pit_watchdog_rtc (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [3:0]  reg_index_i,
  input  logic [31:0] write_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_data_o,
  output logic        irq_o
);
  import stm_pkg::*;

  logic     in_valid_q;
  stm_req_t req_q;
  logic     out_valid_q;
  stm_rsp_t rsp_q;
  stm_rsp_t rsp;
  logic     advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  stm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .req_i  (req_q),
    .rsp_o  (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q.action     <= stm_action_e'(action_i);
      req_q.reg_index  <= stm_reg_e'(reg_index_i);
      req_q.write_data <= write_data_i;
    end
    if (advance) begin
      rsp_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = rsp_q.read_data;
  assign irq_o       = rsp_q.irq;

endmodule

@@ dv/stm_timer_checker.sv @@
`timescale 1ns / 1ps

module stm_timer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  action_i,
  input  logic [3:0]  reg_index_i,
  input  logic [31:0] write_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] read_data_i,
  input  logic        irq_i,
  output int          mismatches_o,
  output int          pending_o,
  output int          checked_o,
  output int          irq_seen_o
);
  import stm_pkg::*;

  logic [15:0]         period_ivl;
  logic [SPAN_W-1:0]   period_left;
  logic [17:0]         wd_mode;
  logic [SPAN_W-1:0]   wd_left;
  logic [WD_PRE_W-1:0] wd_div;
  logic [19:0]         rt_mode;
  logic [SPAN_W-1:0]   rt_div;
  logic [RT_BITS-1:0]  rt_now;
  logic [RT_BITS-1:0]  alarm;
  logic [3:0]          flags;
  logic [3:0]          mask;

  stm_rsp_t pending_rsp[$];
  stm_rsp_t want;
  int       mismatches;
  int       checked;
  int       irq_seen;

  assign mismatches_o = mismatches;
  assign checked_o    = checked;
  assign irq_seen_o   = irq_seen;

  function automatic logic [SPAN_W-1:0] full_span(input logic [15:0] v);
    return (v == 16'd0) ? SPAN_MAX : SPAN_W'(v);
  endfunction

  // Applies one word to the timer state and returns the response it produces.
  function automatic stm_rsp_t step_timer(input logic [1:0] act, input logic [3:0] idx,
                                          input logic [31:0] data);
    stm_rsp_t rsp;
    rsp.read_data = '0;
    case (act)
      ACT_TICK: begin
        period_left = period_left - SPAN_W'(1);
        if (period_left == '0) begin
          flags[FLAG_PIT] = 1'b1;
          period_left     = full_span(period_ivl);
        end
        if (wd_div == WD_PRE_W'(WD_DIV - 1)) begin
          wd_div  = '0;
          wd_left = wd_left - SPAN_W'(1);
          if (wd_left == '0) begin
            flags[FLAG_WDT] = 1'b1;
            wd_left         = full_span(wd_mode[15:0]);
          end
        end else begin
          wd_div = wd_div + WD_PRE_W'(1);
        end
        rt_div = rt_div + SPAN_W'(1);
        if (rt_div >= full_span(rt_mode[15:0])) begin
          rt_div          = '0;
          rt_now          = rt_now + RT_BITS'(1);
          flags[FLAG_RTT] = 1'b1;
          if (rt_now == alarm) begin
            flags[FLAG_ALM] = 1'b1;
          end
        end
      end
      ACT_READ: begin
        case (idx)
          REG_PIMR: rsp.read_data = DATA_W'(period_ivl);
          REG_WDMR: rsp.read_data = DATA_W'(wd_mode);
          REG_RTMR: rsp.read_data = DATA_W'(rt_mode);
          REG_SR: begin
            rsp.read_data = DATA_W'(flags);
            flags         = '0;
          end
          REG_IMR:  rsp.read_data = DATA_W'(mask);
          REG_RTAR: rsp.read_data = DATA_W'(alarm);
          REG_CRTR: rsp.read_data = DATA_W'(rt_now);
          default: ;
        endcase
      end
      ACT_WRITE: begin
        case (idx)
          REG_CR: begin
            if (data[0]) begin
              wd_left = full_span(wd_mode[15:0]);
              wd_div  = '0;
            end
          end
          REG_PIMR: begin
            period_ivl  = data[15:0];
            period_left = full_span(data[15:0]);
          end
          REG_WDMR: wd_mode = data[17:0];
          REG_RTMR: begin
            rt_mode = data[19:0];
            rt_div  = '0;
          end
          REG_IER:  mask = mask | data[3:0];
          REG_IDR:  mask = mask & ~data[3:0];
          REG_RTAR: alarm = data[RT_BITS-1:0];
          default: ;
        endcase
      end
      default: ;
    endcase
    rsp.irq = |(flags & mask);
    return rsp;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    mismatches++;
    if (mismatches <= 40) begin
      $display("[%0t] mismatch on %s: got 0x%08h, predicted 0x%08h", $time, what, got,
               exp_val);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_ivl  <= '0;
      period_left <= SPAN_MAX;
      wd_mode     <= WD_MODE_RST;
      wd_left     <= SPAN_MAX;
      wd_div      <= '0;
      rt_mode     <= RT_MODE_RST;
      rt_div      <= '0;
      rt_now      <= '0;
      alarm       <= '0;
      flags       <= '0;
      mask        <= '0;
      pending_rsp.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        pending_rsp.push_back(step_timer(action_i, reg_index_i, write_data_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_rsp.size() == 0) begin
          report_mismatch("unexpected word", read_data_i, '0);
        end else begin
          want = pending_rsp.pop_front();
          checked++;
          if (irq_i) begin
            irq_seen++;
          end
          if (read_data_i !== want.read_data) begin
            report_mismatch("read_data", read_data_i, want.read_data);
          end
          if (irq_i !== want.irq) begin
            report_mismatch("irq", 32'(irq_i), 32'(want.irq));
          end
        end
      end
    end
    pending_o <= pending_rsp.size();
  end

endmodule

@@ dv/tb_system_timer_pit_watchdog_rtc.sv @@
`timescale 1ns / 1ps

module tb_system_timer_pit_watchdog_rtc;
  import stm_pkg::*;

  localparam logic [1:0] ACT_NONE       = 2'd3;
  localparam logic [3:0] REG_SPARE      = 4'd15;
  localparam int         SQUEEZE_CYCLES = 60;
  localparam int         QUIET_LIMIT    = 2000;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i     = ACT_TICK;
  logic [3:0]  reg_index_i  = REG_CR;
  logic [31:0] write_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [31:0] read_data_o;
  logic        irq_o;

  int   mismatches;
  int   pending;
  int   checked;
  int   irq_seen;
  int   words_sent   = 0;
  int   snd_idle_pct = 0;
  int   rcv_idle_pct = 0;
  logic squeeze_go   = 1'b0;
  logic squeeze_done = 1'b0;
  int   hold_left    = 0;
  int   quiet_cycles = 0;

  always #2 clk_i = ~clk_i;

  system_timer_pit_watchdog_rtc i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .reg_index_i  (reg_index_i),
    .write_data_i (write_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_data_o  (read_data_o),
    .irq_o        (irq_o)
  );

  stm_timer_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .action_i     (action_i),
    .reg_index_i  (reg_index_i),
    .write_data_i (write_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_data_i  (read_data_o),
    .irq_i        (irq_o),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked),
    .irq_seen_o   (irq_seen)
  );

  // The one long output stall is counted here while the sender keeps offering words.
  always @(posedge clk_i) begin
    if (squeeze_go && !squeeze_done) begin
      squeeze_done <= 1'b1;
      hold_left    <= SQUEEZE_CYCLES;
      out_ready_i  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Timeout after %0d cycles without a handshake.", QUIET_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic [1:0] act, input logic [3:0] idx,
                           input logic [31:0] data);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    reg_index_i  <= idx;
    write_data_i <= data;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    words_sent++;
  endtask

  // Mostly small counts and prescales so that the timers expire often.
  task automatic send_random_word();
    logic [1:0]  act;
    logic [3:0]  idx;
    logic [31:0] data;
    int          pick;
    pick = $urandom_range(99);
    data = $urandom();
    idx  = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(9));
    if (pick < 50) begin
      act = ACT_TICK;
    end else if (pick < 72) begin
      act = ACT_READ;
      if ($urandom_range(2) == 0) begin
        idx = REG_SR;
      end
    end else if (pick < 96) begin
      act = ACT_WRITE;
      if ($urandom_range(4) != 0) begin
        data[15:0] = 16'($urandom_range(12));
      end
      if (idx == REG_RTAR && $urandom_range(3) != 0) begin
        data[19:0] = 20'($urandom_range(1200));
      end
    end else begin
      act = ACT_NONE;
    end
    send_word(act, idx, data);
  endtask

  task automatic run_phase(input int n, input int snd_pct, input int rcv_pct);
    snd_idle_pct = snd_pct;
    rcv_idle_pct <= rcv_pct;
    repeat (n) begin
      send_random_word();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    snd_idle_pct = 13;
    rcv_idle_pct <= 66;
    send_word(ACT_READ, REG_PIMR, $urandom());
    send_word(ACT_READ, REG_WDMR, $urandom());
    send_word(ACT_READ, REG_RTMR, $urandom());
    send_word(ACT_READ, REG_CR, $urandom());
    send_word(ACT_READ, REG_SPARE, $urandom());
    send_word(ACT_WRITE, REG_IER, 32'hFFFF_FFFF);
    send_word(ACT_WRITE, REG_IDR, 32'h0000_0005);
    send_word(ACT_READ, REG_IMR, $urandom());
    send_word(ACT_WRITE, REG_IER, 32'h0000_000F);
    send_word(ACT_WRITE, REG_PIMR, 32'hFFFF_FFFF);
    send_word(ACT_READ, REG_PIMR, $urandom());
    send_word(ACT_WRITE, REG_PIMR, 32'h0000_0001);
    send_word(ACT_WRITE, REG_WDMR, 32'hFFFF_FFFF);
    send_word(ACT_READ, REG_WDMR, $urandom());
    send_word(ACT_WRITE, REG_WDMR, 32'h0000_0001);
    send_word(ACT_WRITE, REG_CR, 32'hFFFF_FFFE);
    send_word(ACT_WRITE, REG_CR, 32'h0000_0001);
    send_word(ACT_WRITE, REG_RTMR, 32'h0000_0001);
    send_word(ACT_WRITE, REG_RTAR, 32'hFFFF_FFFF);
    send_word(ACT_READ, REG_RTAR, $urandom());
    send_word(ACT_WRITE, REG_RTAR, 32'h0000_0002);
    repeat (3) send_word(ACT_TICK, REG_CR, $urandom());
    send_word(ACT_READ, REG_CRTR, $urandom());
    send_word(ACT_WRITE, REG_SR, 32'hFFFF_FFFF);
    send_word(ACT_WRITE, REG_IMR, 32'h0000_0000);
    send_word(ACT_WRITE, REG_CRTR, 32'hFFFF_FFFF);
    send_word(ACT_WRITE, REG_SPARE, 32'hFFFF_FFFF);
    send_word(ACT_NONE, REG_SR, 32'hFFFF_FFFF);
    send_word(ACT_READ, REG_SR, $urandom());
    send_word(ACT_READ, REG_IMR, $urandom());

    run_phase(600, 13, 66);
    run_phase(600, 66, 13);
    squeeze_go <= 1'b1;
    run_phase(400, 0, 0);
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);

    $display("Sent %0d words: ticks, reads and writes of every register, unused codes,",
             words_sent);
    $display("under three idling mixes and one long output stall; %0d results checked, %0d %s",
             checked, irq_seen, "with the interrupt raised.");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/stm_pkg.sv
rtl/stm_core.sv
rtl/system_timer_pit_watchdog_rtc.sv
dv/stm_timer_checker.sv
dv/tb_system_timer_pit_watchdog_rtc.sv
